// ===== sv/rfp_pkg.sv =====
package rfp_pkg;

  typedef enum logic [1:0] {
    REG_PAYLOAD_TYPE = 2'd0,
    REG_SENDER_ID    = 2'd1,
    REG_MAX_PACKET   = 2'd2,
    REG_START_SEQ    = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  RTP_VERSION   = 8'h80;
  localparam logic [7:0]  FLAG_KEY      = 8'h80;
  localparam logic [7:0]  FLAG_DEP      = 8'h40;
  localparam logic [7:0]  FLAG_EXT      = 8'h01;
  localparam logic [15:0] EXT_ID_LEN    = 16'h0402;
  localparam logic [4:0]  HDR_KEY_LEN   = 5'd18;
  localparam logic [4:0]  HDR_DEP_LEN   = 5'd19;
  localparam logic [4:0]  EXT_LEN       = 5'd4;

  // One classified word handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]  pay;
    logic        has_hdr;
    logic        has_pay;
    logic        last_pkt;
    logic        ext;
    logic        pkt_end;
    logic        frm_end;
    logic [15:0] seq;
    logic [15:0] pkt_idx;
    logic [15:0] last_idx;
    logic        key;
    logic [7:0]  frame_num;
    logic [7:0]  ref_num;
    logic [31:0] ts;
    logic [15:0] delay;
  } job_t;

endpackage

// ===== sv/rfp_div.sv =====
// Restoring divider, one quotient bit a cycle.
module rfp_div #(
  parameter int W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [13:0]  den_i,
  output logic         busy_o,
  output logic [W-1:0] quo_o
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  num_q, quo_q;
  logic [14:0]   rem_q;
  logic [13:0]   den_q;
  logic [14:0]   trial;

  assign trial  = {rem_q[13:0], num_q[W-1]};
  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      num_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      den_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(W);
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
      num_q <= {num_q[W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== sv/rfp_front.sv =====
// Latches frame fields, counts packets, and classifies each input word.
module rfp_front #(
  parameter int FRAME_LEN_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                payload_byte_i,
  input  logic [FRAME_LEN_BITS-1:0] frame_length_i,
  input  logic                      key_frame_i,
  input  logic [7:0]                frame_number_i,
  input  logic [7:0]                reference_number_i,
  input  logic [31:0]               media_timestamp_i,
  input  logic [15:0]               playout_delay_i,
  input  logic [13:0]               max_packet_bytes_i,
  input  logic                      seq_load_i,
  input  logic [15:0]               seq_value_i,
  output logic                      job_valid_o,
  input  logic                      job_full_i,
  output rfp_pkg::job_t             job_o
);
  localparam int L = FRAME_LEN_BITS;

  typedef enum logic [1:0] {
    ST_IDLE, ST_DIV, ST_RUN
  } state_e;

  state_e        state_q;
  logic [L-1:0]  len_q, off_q;
  logic [13:0]   fill_q, cap_first_q, cap_rest_q;
  logic [15:0]   pidx_q, lidx_q, seq_q;
  logic          key_q;
  logic [7:0]    fnum_q, rnum_q, pay_q;
  logic [31:0]   ts_q;
  logic [15:0]   delay_q;
  logic          pay_hold_q;

  logic [4:0]    hdr_rest, hdr_first;
  logic [13:0]   capr, capf;
  logic          div_start, div_busy;
  logic [L:0]    div_num, div_quo;
  logic [L-1:0]  remain;
  logic [13:0]   cap;
  logic          first, last_pkt, fill_zero, off_end, pkt_full;
  logic          emit, in_take;
  logic [L-1:0]  off_n;
  logic [13:0]   fill_n;

  function automatic logic [13:0] cap_of(input logic [13:0] m, input logic [4:0] h);
    if (m <= {9'd0, h}) cap_of = 14'd1;
    else cap_of = m - {9'd0, h};
  endfunction

  assign hdr_rest  = key_frame_i ? rfp_pkg::HDR_KEY_LEN : rfp_pkg::HDR_DEP_LEN;
  assign hdr_first = hdr_rest + ((playout_delay_i != 16'd0) ? rfp_pkg::EXT_LEN : 5'd0);
  assign capr      = cap_of(max_packet_bytes_i, hdr_rest);
  assign capf      = cap_of(max_packet_bytes_i, hdr_first);

  assign div_start = (state_q == ST_IDLE) && in_valid_i;
  // Numerator is (len - cap_first) + cap_rest - 1 when len exceeds cap_first, else zero.
  // One extra bit keeps the sum from wrapping on the longest frames.
  assign div_num   = (frame_length_i > L'(capf)) ?
                     ({1'b0, frame_length_i} - (L+1)'(capf) + (L+1)'(capr) - (L+1)'(1)) :
                     '0;

  rfp_div #(.W(L + 1)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (capr),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign first     = (off_q == L'(fill_q));
  assign cap       = first ? cap_first_q : cap_rest_q;
  assign remain    = len_q - off_q;
  assign last_pkt  = remain <= L'(cap);
  assign fill_zero = (fill_q == 14'd0);
  assign off_n     = off_q + 1'b1;
  assign fill_n    = fill_q + 1'b1;
  assign off_end   = (len_q == '0) || (off_n >= len_q);
  assign pkt_full  = fill_n >= cap;

  assign emit        = (state_q == ST_RUN) && !job_full_i && pay_hold_q;
  // A mid-frame word may enter while the held one moves on, but not past the frame's end.
  assign in_stall_o  = (state_q != ST_IDLE) &&
                       ((state_q != ST_RUN) || (pay_hold_q && (job_full_i || off_end)));
  assign in_take     = in_valid_i && !in_stall_o;
  assign job_valid_o = emit;

  always_comb begin
    job_o           = '0;
    job_o.pay       = pay_q;
    job_o.has_hdr   = fill_zero;
    job_o.has_pay   = (len_q != '0);
    job_o.last_pkt  = last_pkt;
    job_o.ext       = first && (delay_q != 16'd0);
    job_o.pkt_end   = off_end || pkt_full;
    job_o.frm_end   = off_end;
    job_o.seq       = seq_q;
    job_o.pkt_idx   = pidx_q;
    job_o.last_idx  = lidx_q;
    job_o.key       = key_q;
    job_o.frame_num = fnum_q;
    job_o.ref_num   = rnum_q;
    job_o.ts        = ts_q;
    job_o.delay     = delay_q;
  end

  // The opening word of a frame is held inside the front part while the packet
  // count is worked out; later words are taken into the same hold as the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seq_q       <= '0;
      len_q       <= '0;
      off_q       <= '0;
      fill_q      <= '0;
      pidx_q      <= '0;
      lidx_q      <= '0;
      cap_first_q <= 14'd1;
      cap_rest_q  <= 14'd1;
      key_q       <= 1'b0;
      fnum_q      <= '0;
      rnum_q      <= '0;
      ts_q        <= '0;
      delay_q     <= '0;
      pay_q       <= '0;
      pay_hold_q  <= 1'b0;
    end else begin
      if (seq_load_i) seq_q <= seq_value_i;
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            len_q       <= frame_length_i;
            key_q       <= key_frame_i;
            fnum_q      <= frame_number_i;
            rnum_q      <= reference_number_i;
            ts_q        <= media_timestamp_i;
            delay_q     <= playout_delay_i;
            cap_first_q <= capf;
            cap_rest_q  <= capr;
            pay_q       <= payload_byte_i;
            pay_hold_q  <= 1'b1;
            off_q       <= '0;
            fill_q      <= '0;
            pidx_q      <= '0;
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!div_busy && !div_start) begin
            lidx_q  <= (len_q > L'(cap_first_q)) ? 16'(div_quo) : 16'd0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit) begin
            if (fill_zero && !seq_load_i) seq_q <= seq_q + 1'b1;
            if (off_end) begin
              fill_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              off_q <= off_n;
              if (pkt_full) begin
                fill_q <= '0;
                pidx_q <= pidx_q + 1'b1;
              end else begin
                fill_q <= fill_n;
              end
            end
          end
          if (in_take) begin
            pay_q      <= payload_byte_i;
            pay_hold_q <= 1'b1;
          end else if (emit) begin
            pay_hold_q <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/rfp_back.sv =====
// Serializes one classified word into its header bytes and payload byte.
module rfp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_full_o,
  input  rfp_pkg::job_t job_i,
  input  logic [6:0]    payload_type_i,
  input  logic [31:0]   sender_id_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          packet_end_o,
  output logic          frame_end_o,
  output logic          run_last_o
);
  localparam int QD = 2;

  rfp_pkg::job_t q_mem [QD];
  logic [0:0]    wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic [4:0]    pos_q;
  rfp_pkg::job_t j;
  logic [4:0]    nhdr, total;
  logic [4:0]    p;
  logic [7:0]    b;
  logic          fin, adv;

  assign j          = q_mem[rp_q];
  assign job_full_o = (cnt_q == 2'(QD));
  assign nhdr       = j.has_hdr ? (5'd18 + (j.key ? 5'd0 : 5'd1) + (j.ext ? 5'd4 : 5'd0)) : 5'd0;
  assign total      = nhdr + (j.has_pay ? 5'd1 : 5'd0);
  assign fin        = (pos_q == total - 1'b1);
  assign out_valid_o = (cnt_q != 2'd0);
  assign adv        = out_valid_o && !out_stall_i;

  always_comb begin
    p = pos_q;
    b = 8'h00;
    if (pos_q >= nhdr) begin
      b = j.pay;
    end else if (pos_q < 5'd18) begin
      case (p)
        5'd0:  b = rfp_pkg::RTP_VERSION;
        5'd1:  b = {j.last_pkt, payload_type_i};
        5'd2:  b = j.seq[15:8];
        5'd3:  b = j.seq[7:0];
        5'd4:  b = j.ts[31:24];
        5'd5:  b = j.ts[23:16];
        5'd6:  b = j.ts[15:8];
        5'd7:  b = j.ts[7:0];
        5'd8:  b = sender_id_i[31:24];
        5'd9:  b = sender_id_i[23:16];
        5'd10: b = sender_id_i[15:8];
        5'd11: b = sender_id_i[7:0];
        5'd12: b = (j.key ? rfp_pkg::FLAG_KEY : rfp_pkg::FLAG_DEP) |
                   (j.ext ? rfp_pkg::FLAG_EXT : 8'h00);
        5'd13: b = j.frame_num;
        5'd14: b = j.pkt_idx[15:8];
        5'd15: b = j.pkt_idx[7:0];
        5'd16: b = j.last_idx[15:8];
        default: b = j.last_idx[7:0];
      endcase
    end else begin
      if (!j.key) p = pos_q - 5'd1;
      if (pos_q == 5'd18 && !j.key) b = j.ref_num;
      else begin
        case (p)
          5'd18:   b = rfp_pkg::EXT_ID_LEN[15:8];
          5'd19:   b = rfp_pkg::EXT_ID_LEN[7:0];
          5'd20:   b = j.delay[15:8];
          default: b = j.delay[7:0];
        endcase
      end
    end
  end

  assign out_byte_o   = b;
  assign run_last_o   = fin;
  assign packet_end_o = fin && j.pkt_end;
  assign frame_end_o  = fin && j.frm_end;

  always_ff @(posedge clk_i) begin
    if (job_valid_i && !job_full_o) q_mem[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      if (job_valid_i && !job_full_o) wp_q <= wp_q + 1'b1;
      if (adv) begin
        if (fin) begin
          pos_q <= '0;
          rp_q  <= rp_q + 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      cnt_q <= cnt_q + 2'(job_valid_i && !job_full_o) - 2'(adv && fin);
    end
  end
endmodule

// ===== sv/rtp_frame_packetizer_core.sv =====
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/stall    | payload byte and frame fields
// out     | output    | out_valid/stall   | out_byte, packet_end, frame_end, run_last
// cfg     | input     | cfg_valid/ready   | cfg_index, cfg_data
// A word that opens a frame stalls the input while the one-bit-per-cycle packet count
// divider runs; later words enter one a cycle while the queue is not full.
// Output runs one byte a cycle while out_stall is low: 18 to 24 bytes for a word that opens a packet, else one.
// Reset clears all control state and loads register reset values.
// A two-entry queue parts classification from serialization; the word that ends a
// frame stalls the input until it has entered the queue.
module rtp_frame_packetizer_core #(
  parameter int FRAME_LEN_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                payload_byte_i,
  input  logic [FRAME_LEN_BITS-1:0] frame_length_i,
  input  logic                      key_frame_i,
  input  logic [7:0]                frame_number_i,
  input  logic [7:0]                reference_number_i,
  input  logic [31:0]               media_timestamp_i,
  input  logic [15:0]               playout_delay_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      packet_end_o,
  output logic                      frame_end_o,
  output logic                      run_last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i
);
  logic [6:0]    ptype_q;
  logic [31:0]   sender_q;
  logic [13:0]   maxpkt_q;
  logic          wr, seq_load;
  logic          job_valid, job_full;
  rfp_pkg::job_t job;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign seq_load    = wr && (cfg_index_i == rfp_pkg::REG_START_SEQ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptype_q  <= 7'd96;
      sender_q <= '0;
      maxpkt_q <= 14'd1400;
    end else if (wr) begin
      case (cfg_index_i)
        rfp_pkg::REG_PAYLOAD_TYPE: ptype_q  <= cfg_data_i[6:0];
        rfp_pkg::REG_SENDER_ID:    sender_q <= cfg_data_i;
        rfp_pkg::REG_MAX_PACKET:   maxpkt_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  rfp_front #(.FRAME_LEN_BITS(FRAME_LEN_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .payload_byte_i, .frame_length_i,
    .key_frame_i, .frame_number_i, .reference_number_i, .media_timestamp_i,
    .playout_delay_i,
    .max_packet_bytes_i (maxpkt_q),
    .seq_load_i         (seq_load),
    .seq_value_i        (cfg_data_i[15:0]),
    .job_valid_o        (job_valid),
    .job_full_i         (job_full),
    .job_o              (job)
  );

  rfp_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i    (job_valid),
    .job_full_o     (job_full),
    .job_i          (job),
    .payload_type_i (ptype_q),
    .sender_id_i    (sender_q),
    .out_valid_o, .out_stall_i, .out_byte_o, .packet_end_o, .frame_end_o, .run_last_o
  );
endmodule

// ===== sv/rfp_checker.sv =====
module rfp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic packet_end_o,
  input logic frame_end_o,
  input logic run_last_o
);
  a_frame_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> packet_end_o) else $error("frame end without packet end");
  a_packet_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_end_o |-> run_last_o) else $error("packet end mid word");
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("valid dropped under stall");
endmodule

bind rtp_frame_packetizer_core rfp_checker u_chk (.*);

// ===== verif/rtp_frame_packetizer_core_tb.sv =====
module rtp_frame_packetizer_core_tb;

  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [7:0]  pay;
    logic [23:0] len;
    logic        key;
    logic [7:0]  fnum;
    logic [7:0]  rnum;
    logic [31:0] ts;
    logic [15:0] delay;
  } frame_word_t;

  typedef struct {
    logic [7:0] data;
    logic       pend;
    logic       fend;
    logic       run_last;
  } stream_byte_t;

  typedef struct {
    frame_word_t w;
    int          n_bytes;  // 0: checked by the predictor only
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  pay_byte = '0;
  logic [23:0] frame_len = '0;
  logic        key_frame = 1'b0;
  logic [7:0]  frame_num = '0;
  logic [7:0]  ref_num = '0;
  logic [31:0] media_ts = '0;
  logic [15:0] play_delay = '0;
  logic        out_stall = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_stall, out_valid, cfg_ready;
  logic [7:0]  out_byte;
  logic        packet_end, frame_end, run_last;

  rtp_frame_packetizer_core #(.FRAME_LEN_BITS(24)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .payload_byte_i(pay_byte), .frame_length_i(frame_len), .key_frame_i(key_frame),
    .frame_number_i(frame_num), .reference_number_i(ref_num),
    .media_timestamp_i(media_ts), .playout_delay_i(play_delay),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_byte_o(out_byte), .packet_end_o(packet_end), .frame_end_o(frame_end),
    .run_last_o(run_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #10 clk = ~clk;

  // Register copies and packetizer state of the predictor.
  logic [6:0]  pt_reg;
  logic [31:0] ssrc_reg;
  logic [13:0] max_pkt_reg;
  logic [15:0] seq_cnt;
  logic        in_frm;
  int unsigned offs, fill, cap_first, cap_rest;
  logic [15:0] pkt_idx, last_idx;
  frame_word_t held;

  stream_byte_t pkt_stream_q[$];
  int errors = 0;
  int words_sent = 0, bytes_seen = 0, packets_seen = 0, frames_seen = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch: %s got %0h expected %0h", what, got, want);
  endtask

  function automatic int unsigned cap_of(int unsigned hdr);
    return (max_pkt_reg <= hdr) ? 1 : max_pkt_reg - hdr;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    stream_byte_t s;
    s.data = b;
    s.pend = 1'b0;
    s.fend = 1'b0;
    s.run_last = 1'b0;
    pkt_stream_q.insert(pkt_stream_q.size(), s);
  endfunction

  // Sets flags on the newest expected byte.
  function automatic void flag_tail(logic pend, logic fend, logic rl);
    stream_byte_t s;
    s = pkt_stream_q[pkt_stream_q.size() - 1];
    s.pend = s.pend | pend;
    s.fend = s.fend | fend;
    s.run_last = s.run_last | rl;
    pkt_stream_q[pkt_stream_q.size() - 1] = s;
  endfunction

  function automatic void predict_packet_bytes(frame_word_t w);
    int unsigned hdr, cap;
    longint unsigned count;
    logic first, lastp, ext;
    if (!in_frm) begin
      held = w;
      hdr = w.key ? rfp_pkg::HDR_KEY_LEN : rfp_pkg::HDR_DEP_LEN;
      cap_rest = cap_of(hdr);
      cap_first = cap_of(hdr + (w.delay != 0 ? rfp_pkg::EXT_LEN : 0));
      count = 1;
      if (w.len > cap_first)
        count = 1 + (longint'(w.len - cap_first) + cap_rest - 1) / cap_rest;
      last_idx = 16'(count - 1);
      pkt_idx = '0;
      offs = 0;
      fill = 0;
      in_frm = 1'b1;
    end
    first = (offs == fill);
    ext = first && held.delay != 0;
    cap = first ? cap_first : cap_rest;
    if (fill == 0) begin
      lastp = (held.len - offs) <= cap;
      push_byte(rfp_pkg::RTP_VERSION);
      push_byte({lastp, pt_reg});
      push_byte(seq_cnt[15:8]);
      push_byte(seq_cnt[7:0]);
      push_byte(held.ts[31:24]);
      push_byte(held.ts[23:16]);
      push_byte(held.ts[15:8]);
      push_byte(held.ts[7:0]);
      push_byte(ssrc_reg[31:24]);
      push_byte(ssrc_reg[23:16]);
      push_byte(ssrc_reg[15:8]);
      push_byte(ssrc_reg[7:0]);
      push_byte((held.key ? rfp_pkg::FLAG_KEY : rfp_pkg::FLAG_DEP) |
                (ext ? rfp_pkg::FLAG_EXT : 8'h00));
      push_byte(held.fnum);
      push_byte(pkt_idx[15:8]);
      push_byte(pkt_idx[7:0]);
      push_byte(last_idx[15:8]);
      push_byte(last_idx[7:0]);
      if (!held.key) push_byte(held.rnum);
      if (ext) begin
        push_byte(rfp_pkg::EXT_ID_LEN[15:8]);
        push_byte(rfp_pkg::EXT_ID_LEN[7:0]);
        push_byte(held.delay[15:8]);
        push_byte(held.delay[7:0]);
      end
      seq_cnt = seq_cnt + 16'd1;
    end
    if (held.len == 0) begin
      flag_tail(1'b1, 1'b1, 1'b0);
      in_frm = 1'b0;
    end else begin
      offs++;
      fill++;
      push_byte(w.pay);
      if (offs >= held.len) begin
        flag_tail(1'b1, 1'b1, 1'b0);
        in_frm = 1'b0;
        fill = 0;
      end else if (fill >= cap) begin
        flag_tail(1'b1, 1'b0, 1'b0);
        fill = 0;
        pkt_idx = pkt_idx + 16'd1;
      end
    end
    flag_tail(1'b0, 1'b0, 1'b1);
  endfunction

  function automatic frame_word_t mk_word(logic [7:0] pay, logic [23:0] len, logic key,
                                         logic [7:0] fn, logic [7:0] rn, logic [31:0] ts,
                                         logic [15:0] dl);
    frame_word_t w;
    w.pay = pay; w.len = len; w.key = key; w.fnum = fn; w.rnum = rn; w.ts = ts; w.delay = dl;
    return w;
  endfunction

  function automatic frame_word_t rand_word();
    return mk_word(8'($urandom), 24'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                   $urandom, 16'($urandom));
  endfunction

  // Drives one word, holding valid high across back-to-back words.
  task automatic send_word(frame_word_t w, output int n_new);
    int gap;
    int q_size0;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pay_byte <= w.pay;
    frame_len <= w.len;
    key_frame <= w.key;
    frame_num <= w.fnum;
    ref_num <= w.rnum;
    media_ts <= w.ts;
    play_delay <= w.delay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    q_size0 = pkt_stream_q.size();
    predict_packet_bytes(w);
    n_new = pkt_stream_q.size() - q_size0;
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pkt_stream_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Leaves valid high so that writes can follow back to back.
  task automatic cfg_write(rfp_pkg::reg_idx_e idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rfp_pkg::REG_PAYLOAD_TYPE: pt_reg = data[6:0];
      rfp_pkg::REG_SENDER_ID:    ssrc_reg = data;
      rfp_pkg::REG_MAX_PACKET:   max_pkt_reg = data[13:0];
      rfp_pkg::REG_START_SEQ:    seq_cnt = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] pt, logic [31:0] sid, logic [31:0] mx,
                          logic [31:0] sq);
    cfg_write(rfp_pkg::REG_PAYLOAD_TYPE, pt);
    cfg_write(rfp_pkg::REG_SENDER_ID, sid);
    cfg_write(rfp_pkg::REG_MAX_PACKET, mx);
    cfg_write(rfp_pkg::REG_START_SEQ, sq);
    cfg_valid <= 1'b0;
  endtask

  // Random frames: an opening word, then mid-frame words whose extra fields are noise.
  task automatic run_frames(int n_words);
    int sent, r, len, n;
    logic paused;
    frame_word_t w;
    sent = 0;
    paused = 1'b0;
    while (sent < n_words) begin
      r = $urandom_range(0, 9);
      len = (r == 0) ? 0 : (r == 9) ? 1 : (r == 8) ? $urandom_range(41, 150)
                                                  : $urandom_range(2, 40);
      w = rand_word();
      w.len = 24'(len);
      if ($urandom_range(0, 2) == 0) w.delay = '0;
      send_word(w, n);
      sent++;
      for (int i = 1; i < len; i++) begin
        send_word(rand_word(), n);
        sent++;
      end
      if (!paused && sent >= n_words / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    wait_drained();
  endtask

  dir_row_t dir_rows[8];

  initial begin
    int n;
    pt_reg = 7'd96;
    ssrc_reg = '0;
    max_pkt_reg = 14'd1400;
    seq_cnt = '0;
    in_frm = 1'b0;
    offs = 0; fill = 0; cap_first = 1; cap_rest = 1;
    pkt_idx = '0; last_idx = '0;
    dir_rows[0] = '{mk_word(8'h00, 24'd0, 1'b1, 8'h00, 8'h00, 32'h0, 16'h0), 18};
    dir_rows[1] = '{mk_word(8'hFF, 24'd0, 1'b0, 8'h01, 8'h02, 32'h1, 16'h0), 19};
    dir_rows[2] = '{mk_word(8'h00, 24'd0, 1'b0, 8'h10, 8'h20, 32'h5, 16'hFFFF), 23};
    dir_rows[3] = '{mk_word(8'h00, 24'd0, 1'b1, 8'h11, 8'h00, 32'h6, 16'h0001), 22};
    dir_rows[4] = '{mk_word(8'hFF, 24'd1, 1'b1, 8'hFF, 8'h00, 32'hFFFFFFFF, 16'h0), 19};
    dir_rows[5] = '{mk_word(8'h00, 24'd3, 1'b0, 8'h33, 8'h32, 32'h12345678, 16'h0), 20};
    dir_rows[6] = '{mk_word(8'hA5, 24'd0, 1'b1, 8'hEE, 8'hDD, 32'hCAFE, 16'h7), 1};
    dir_rows[7] = '{mk_word(8'h5A, 24'hFFFFFF, 1'b1, 8'h0, 8'h0, 32'h0, 16'h0), 1};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, n);
      if (dir_rows[i].n_bytes != 0 && n != dir_rows[i].n_bytes)
        report_mismatch($sformatf("byte count of directed row %0d", i), n,
                        dir_rows[i].n_bytes);
    end
    send_word(mk_word(8'h00, 24'd0, 1'b0, 8'hFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF), n);
    if (n != 23) report_mismatch("byte count of all-ones empty frame", n, 23);
    wait_drained();

    // Extremes first, then random settings, one with a packet size no larger than the longest header.
    set_regs(32'h0, 32'h0, 32'd24, 32'hFFFE);
    run_frames(80);
    set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h3FFF, 32'hFFFF);
    run_frames(60);
    set_regs($urandom, $urandom, $urandom_range(24, 70), $urandom);
    run_frames(90);
    set_regs($urandom, $urandom, $urandom_range(0, 23), $urandom);
    run_frames(70);
    set_regs($urandom, $urandom, $urandom_range(30, 200), $urandom);
    run_frames(80);

    $display("covered %0d input words, %0d frames, %0d packets, %0d stream bytes",
             words_sent, frames_seen, packets_seen, bytes_seen);
    $display("over six register settings including extreme and undersized packet sizes");
    if (errors == 0) begin
      $display("** rtp_frame_packetizer_core: PASSED **");
    end else begin
      $display("** rtp_frame_packetizer_core: FAILED **");
    end
    $finish;
  end

  // Output side: random stall before each word, with stretches of none.
  initial begin
    int w;
    stream_byte_t e;
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      bytes_seen++;
      if (packet_end) packets_seen++;
      if (frame_end) frames_seen++;
      if (pkt_stream_q.size() == 0) begin
        report_mismatch("unexpected output word", out_byte, 0);
      end else begin
        e = pkt_stream_q.pop_front();
        if (out_byte !== e.data) report_mismatch("out_byte", out_byte, e.data);
        if (packet_end !== e.pend) report_mismatch("packet_end", packet_end, e.pend);
        if (frame_end !== e.fend) report_mismatch("frame_end", frame_end, e.fend);
        if (run_last !== e.run_last) report_mismatch("run_last", run_last, e.run_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("** rtp_frame_packetizer_core: FAILED **");
      $finish;
    end
  end

endmodule
